FILE: hw/rtl/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// Types, constants and tables of the waypoint follow controller.
// ----------------------------------------------------------------------------
package wpf_pkg;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_AW-1:0] REG_ARRIVE_TOL = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ANGLE_TOL  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_FWD_SPEED  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TURN_RATE  = 2'd3;

    localparam logic [15:0] RST_ARRIVE_TOL = 16'd205;
    localparam logic [14:0] RST_ANGLE_TOL  = 15'd1820;
    localparam logic [15:0] RST_FWD_SPEED  = 16'd410;
    localparam logic [15:0] RST_TURN_RATE  = 16'd2048;

    localparam int CW = 38;
    localparam int CORDIC_MAX = 24;
    localparam logic [16:0] TWO_PI_Q13 = 17'd51472;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] linear_speed;
        logic signed [19:0] angular_rate;
        logic        [2:0]  target_index;
        logic               finished;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_YAW0, S_YAWW,
        S_ORG, S_D0, S_D1, S_D2, S_D3, S_D4, S_BRG, S_ERR, S_P1, S_P2, S_OUT
    } t_state;

    function automatic logic [23:0] cordic_atan(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:  v = 24'd2097152;
            5'd1:  v = 24'd1238021;
            5'd2:  v = 24'd654136;
            5'd3:  v = 24'd332050;
            5'd4:  v = 24'd166669;
            5'd5:  v = 24'd83416;
            5'd6:  v = 24'd41718;
            5'd7:  v = 24'd20860;
            5'd8:  v = 24'd10430;
            5'd9:  v = 24'd5215;
            5'd10: v = 24'd2608;
            5'd11: v = 24'd1304;
            5'd12: v = 24'd652;
            5'd13: v = 24'd326;
            5'd14: v = 24'd163;
            5'd15: v = 24'd81;
            5'd16: v = 24'd41;
            5'd17: v = 24'd20;
            5'd18: v = 24'd10;
            5'd19: v = 24'd5;
            5'd20: v = 24'd3;
            5'd21: v = 24'd1;
            5'd22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [23:0] wp_x(input logic [1:0] i);
        return (i == 2'd0 || i == 2'd1) ? 24'sd2048 : 24'sd0;
    endfunction

    function automatic logic signed [23:0] wp_y(input logic [1:0] i);
        return (i == 2'd1 || i == 2'd2) ? 24'sd2048 : 24'sd0;
    endfunction

endpackage

FILE: hw/rtl/waypoint_follow_controller.sv
// ----------------------------------------------------------------------------
// waypoint_follow_controller
// Go-to-goal controller: one odometry item in, one motion command item out.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries one odometry item (position and
// quaternion). Output channel o_out_valid/i_out_ready carries one command item.
// The config port (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata) writes the arrival
// tolerance, angle tolerance, forward speed and turn rate; write only while idle.
// One item is handled at a time. A shared multiplier and one iterative CORDIC
// unit do the work: seven multiply steps for yaw, one CORDIC pass for the yaw
// angle, five distance steps, a second CORDIC pass for the bearing, then up
// to three steering steps. An arrival or finished item skips the bearing pass
// and the steering steps, and a finished item also skips the distance steps.
// o_in_ready is high only while idle, so the next item is taken only after
// the command item for the last one has been taken.
// The command item is held in a register until taken; a stalled receiver
// keeps the block busy. Reset clears the origin, waypoint index and finished
// flag and restores the register defaults.
// ----------------------------------------------------------------------------
module waypoint_follow_controller #(
    parameter int WAYPOINT_COUNT = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  wpf_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output wpf_pkg::t_out_item            o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [wpf_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [wpf_pkg::CFG_DW-1:0]    i_cfg_wdata
);
    localparam int IW = $clog2(WAYPOINT_COUNT + 1);

    wpf_pkg::t_state    r_state, n_state;
    wpf_pkg::t_in_item  r_in;
    wpf_pkg::t_out_item r_out;

    logic [15:0] r_arrive_tol;
    logic [14:0] r_angle_tol;
    logic [15:0] r_fwd_speed;
    logic [15:0] r_turn_rate;

    logic               r_have_org;
    logic signed [23:0] r_org_x;
    logic signed [23:0] r_org_y;
    logic [15:0]        r_org_yaw;
    logic [IW-1:0]      r_idx;
    logic               r_done;

    logic signed [60:0] r_prod;
    logic signed [61:0] r_acc;
    logic signed [33:0] r_num;
    logic signed [34:0] r_den;
    logic [15:0]        r_yaw;
    logic signed [25:0] r_dx;
    logic signed [25:0] r_dy;
    logic signed [15:0] r_err;

    logic signed [33:0] w_ma;
    logic signed [26:0] w_mb;
    logic               w_cs;
    logic signed [wpf_pkg::CW-1:0] w_cx;
    logic signed [wpf_pkg::CW-1:0] w_cy;
    logic               w_cdone;
    logic [15:0]        w_cang;
    logic signed [34:0] w_num2;
    logic [IW+2:0]      w_idx_ext;
    logic [IW-1:0]      w_idx_nx;
    logic signed [24:0] w_rx;
    logic signed [24:0] w_ry;
    logic               w_arrive;
    logic signed [16:0] w_e17;
    logic signed [16:0] w_at17;
    logic               w_turn;
    logic [19:0]        w_tr20;
    logic signed [61:0] w_pr;
    logic signed [61:0] w_neg;
    logic signed [19:0] w_ang;

    assign o_in_ready  = (r_state == wpf_pkg::S_IDLE);
    assign o_out_valid = (r_state == wpf_pkg::S_OUT);
    assign o_out       = r_out;

    assign w_num2    = {r_num, 1'b0};
    assign w_idx_ext = {3'b000, r_idx};
    assign w_idx_nx  = r_idx + 1'b1;
    assign w_rx      = 25'(r_in.pos_x) - 25'(r_org_x);
    assign w_ry      = 25'(r_in.pos_y) - 25'(r_org_y);
    assign w_arrive  = r_acc < 62'(r_prod);
    assign w_e17     = 17'(r_err);
    assign w_at17    = {2'b00, r_angle_tol};
    assign w_turn    = r_err[15] ? ((w_e17 + w_at17) < 17'sd0) : (w_e17 > w_at17);
    assign w_tr20    = {4'b0000, r_turn_rate};
    assign w_pr      = 62'(r_prod) + (62'sd1 <<< 28);
    assign w_neg     = -(w_pr >>> 29);

    always_comb begin
        if (w_neg > 62'sd524287) begin
            w_ang = 20'sd524287;
        end else if (w_neg < -62'sd524288) begin
            w_ang = -20'sd524288;
        end else begin
            w_ang = w_neg[19:0];
        end
    end

    wpf_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cs),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .o_done  (w_cdone),
        .o_angle (w_cang)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            wpf_pkg::S_IDLE: if (i_in_valid) n_state = wpf_pkg::S_Q0;
            wpf_pkg::S_Q0:   n_state = wpf_pkg::S_Q1;
            wpf_pkg::S_Q1:   n_state = wpf_pkg::S_Q2;
            wpf_pkg::S_Q2:   n_state = wpf_pkg::S_Q3;
            wpf_pkg::S_Q3:   n_state = wpf_pkg::S_Q4;
            wpf_pkg::S_Q4:   n_state = wpf_pkg::S_Q5;
            wpf_pkg::S_Q5:   n_state = wpf_pkg::S_Q6;
            wpf_pkg::S_Q6:   n_state = wpf_pkg::S_YAW0;
            wpf_pkg::S_YAW0: n_state = wpf_pkg::S_YAWW;
            wpf_pkg::S_YAWW: if (w_cdone) n_state = wpf_pkg::S_ORG;
            wpf_pkg::S_ORG:  n_state = r_done ? wpf_pkg::S_OUT : wpf_pkg::S_D0;
            wpf_pkg::S_D0:   n_state = wpf_pkg::S_D1;
            wpf_pkg::S_D1:   n_state = wpf_pkg::S_D2;
            wpf_pkg::S_D2:   n_state = wpf_pkg::S_D3;
            wpf_pkg::S_D3:   n_state = wpf_pkg::S_D4;
            wpf_pkg::S_D4:   n_state = w_arrive ? wpf_pkg::S_OUT : wpf_pkg::S_BRG;
            wpf_pkg::S_BRG:  if (w_cdone) n_state = wpf_pkg::S_ERR;
            wpf_pkg::S_ERR:  n_state = w_turn ? wpf_pkg::S_OUT : wpf_pkg::S_P1;
            wpf_pkg::S_P1:   n_state = wpf_pkg::S_P2;
            wpf_pkg::S_P2:   n_state = wpf_pkg::S_OUT;
            wpf_pkg::S_OUT:  if (i_out_ready) n_state = wpf_pkg::S_IDLE;
            default:         n_state = wpf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_cs = 1'b0;
        w_cx = wpf_pkg::CW'(r_den);
        w_cy = wpf_pkg::CW'(w_num2);
        case (r_state)
            wpf_pkg::S_Q0: begin
                w_ma = 34'(r_in.quat_w);
                w_mb = 27'(r_in.quat_z);
            end
            wpf_pkg::S_Q1: begin
                w_ma = 34'(r_in.quat_x);
                w_mb = 27'(r_in.quat_y);
            end
            wpf_pkg::S_Q2: begin
                w_ma = 34'(r_in.quat_w);
                w_mb = 27'(r_in.quat_w);
            end
            wpf_pkg::S_Q3: begin
                w_ma = 34'(r_in.quat_x);
                w_mb = 27'(r_in.quat_x);
            end
            wpf_pkg::S_Q4: begin
                w_ma = 34'(r_in.quat_y);
                w_mb = 27'(r_in.quat_y);
            end
            wpf_pkg::S_Q5: begin
                w_ma = 34'(r_in.quat_z);
                w_mb = 27'(r_in.quat_z);
            end
            wpf_pkg::S_YAW0: w_cs = 1'b1;
            wpf_pkg::S_D1: begin
                w_ma = 34'(r_dx);
                w_mb = 27'(r_dx);
            end
            wpf_pkg::S_D2: begin
                w_ma = 34'(r_dy);
                w_mb = 27'(r_dy);
            end
            wpf_pkg::S_D3: begin
                w_ma = 34'({1'b0, r_arrive_tol});
                w_mb = 27'({1'b0, r_arrive_tol});
            end
            wpf_pkg::S_D4: begin
                w_cs = !w_arrive;
                w_cx = wpf_pkg::CW'(r_dx);
                w_cy = wpf_pkg::CW'(r_dy);
            end
            wpf_pkg::S_ERR: begin
                w_ma = 34'({1'b0, r_turn_rate});
                w_mb = 27'(wpf_pkg::TWO_PI_Q13);
            end
            wpf_pkg::S_P1: begin
                w_ma = r_prod[33:0];
                w_mb = 27'(r_err);
            end
            default: begin
                w_cs = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wpf_pkg::S_IDLE;
            r_arrive_tol <= wpf_pkg::RST_ARRIVE_TOL;
            r_angle_tol  <= wpf_pkg::RST_ANGLE_TOL;
            r_fwd_speed  <= wpf_pkg::RST_FWD_SPEED;
            r_turn_rate  <= wpf_pkg::RST_TURN_RATE;
            r_have_org   <= 1'b0;
            r_org_x      <= '0;
            r_org_y      <= '0;
            r_org_yaw    <= '0;
            r_idx        <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    wpf_pkg::REG_ARRIVE_TOL: r_arrive_tol <= i_cfg_wdata;
                    wpf_pkg::REG_ANGLE_TOL:  r_angle_tol  <= i_cfg_wdata[14:0];
                    wpf_pkg::REG_FWD_SPEED:  r_fwd_speed  <= i_cfg_wdata;
                    wpf_pkg::REG_TURN_RATE:  r_turn_rate  <= i_cfg_wdata;
                    default: r_turn_rate <= r_turn_rate;
                endcase
            end
            if (r_state == wpf_pkg::S_ORG && !r_have_org) begin
                r_have_org <= 1'b1;
                r_org_x    <= r_in.pos_x;
                r_org_y    <= r_in.pos_y;
                r_org_yaw  <= r_yaw;
            end
            if (r_state == wpf_pkg::S_D4 && w_arrive) begin
                r_idx <= w_idx_nx;
                if (w_idx_nx == IW'(WAYPOINT_COUNT)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            wpf_pkg::S_IDLE: r_in <= i_in;
            wpf_pkg::S_Q1:   r_num <= 34'(r_prod);
            wpf_pkg::S_Q2:   r_num <= r_num + 34'(r_prod);
            wpf_pkg::S_Q3:   r_den <= 35'(r_prod);
            wpf_pkg::S_Q4:   r_den <= r_den + 35'(r_prod);
            wpf_pkg::S_Q5:   r_den <= r_den - 35'(r_prod);
            wpf_pkg::S_Q6:   r_den <= r_den - 35'(r_prod);
            wpf_pkg::S_YAWW: r_yaw <= w_cang;
            wpf_pkg::S_ORG: begin
                r_out.linear_speed <= '0;
                r_out.angular_rate <= '0;
                r_out.target_index <= w_idx_ext[2:0];
                r_out.finished     <= 1'b1;
            end
            wpf_pkg::S_D0: begin
                r_dx <= 26'(wpf_pkg::wp_x(w_idx_ext[1:0])) - 26'(w_rx);
                r_dy <= 26'(wpf_pkg::wp_y(w_idx_ext[1:0])) - 26'(w_ry);
            end
            wpf_pkg::S_D2: r_acc <= 62'(r_prod);
            wpf_pkg::S_D3: r_acc <= r_acc + 62'(r_prod);
            wpf_pkg::S_D4: begin
                r_out.linear_speed <= '0;
                r_out.angular_rate <= '0;
                r_out.target_index <= 3'(w_idx_ext + 1'b1);
                r_out.finished     <= (w_idx_nx == IW'(WAYPOINT_COUNT));
            end
            wpf_pkg::S_BRG: r_err <= r_yaw - r_org_yaw - w_cang;
            wpf_pkg::S_ERR: begin
                r_out.linear_speed <= '0;
                r_out.angular_rate <= r_err[15] ? w_tr20 : (20'd0 - w_tr20);
                r_out.target_index <= w_idx_ext[2:0];
                r_out.finished     <= 1'b0;
            end
            wpf_pkg::S_P2: begin
                r_out.linear_speed <= r_fwd_speed;
                r_out.angular_rate <= w_ang;
            end
            default: r_acc <= r_acc;
        endcase
    end

    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a command item is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready again right after an item was accepted");

    a_finished_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.finished) |->
        (o_out.linear_speed == 16'd0 && o_out.angular_rate == 20'sd0))
        else $error("nonzero command with finished set");

endmodule

FILE: hw/rtl/wpf_cordic.sv
// ----------------------------------------------------------------------------
// wpf_cordic
// Iterative vectoring CORDIC: atan2(y, x) as a 16-bit binary angle.
// ----------------------------------------------------------------------------
module wpf_cordic #(
    parameter int STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [wpf_pkg::CW-1:0] i_x,
    input  logic signed [wpf_pkg::CW-1:0] i_y,
    output logic                         o_done,
    output logic [15:0]                  o_angle
);
    localparam int N = (STEPS < wpf_pkg::CORDIC_MAX) ? STEPS : wpf_pkg::CORDIC_MAX;
    localparam int CNT_W = $clog2(N + 1);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_i;
    logic                         r_zero;
    logic signed [wpf_pkg::CW-1:0] r_x;
    logic signed [wpf_pkg::CW-1:0] r_y;
    logic [23:0]                  r_z;
    logic signed [wpf_pkg::CW-1:0] w_sx;
    logic signed [wpf_pkg::CW-1:0] w_sy;
    logic [23:0]                  w_rnd;
    logic [23:0]                  w_step;
    logic                         w_last;

    assign w_sx   = r_x >>> r_i;
    assign w_sy   = r_y >>> r_i;
    assign w_step = wpf_pkg::cordic_atan(5'(r_i));
    assign w_last = (r_i == CNT_W'(N));
    assign w_rnd  = r_z + 24'd128;
    assign o_done = r_busy && w_last;
    assign o_angle = r_zero ? 16'd0 : w_rnd[23:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= 24'h800000;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= 24'd0;
            end
        end else if (r_busy && !w_last) begin
            r_i <= r_i + 1'b1;
            if (r_y < 0) begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_step;
            end else begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_step;
            end
        end
    end

endmodule

FILE: tb/sv/waypoint_follow_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waypoint_follow_controller_test
// Self-checking bench: odometry items go in, every command item out is
// compared field by field against a cycle-free predictor of the controller.
// ----------------------------------------------------------------------------
class steer_scoreboard;
    localparam int NUM_WP = 4;
    localparam int CORDIC_ITERS = 16;

    int unsigned arrive_tol, angle_tol, fwd_speed, turn_rate;
    bit          origin_set, all_done;
    longint      org_x, org_y;
    bit [15:0]   org_yaw;
    int unsigned wp_idx;
    longint      wp_xs[NUM_WP], wp_ys[NUM_WP];
    int unsigned atan_steps[24];
    wpf_pkg::t_out_item cmd_q[$];
    int          errors;

    function new();
        atan_steps = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                       20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
                       41, 20, 10, 5, 3, 1, 1, 0};
        for (int i = 0; i < NUM_WP; i++) begin
            wp_xs[i] = (i % 4 == 0 || i % 4 == 1) ? 2048 : 0;
            wp_ys[i] = (i % 4 == 1 || i % 4 == 2) ? 2048 : 0;
        end
        arrive_tol = 205;
        angle_tol  = 1820;
        fwd_speed  = 410;
        turn_rate  = 2048;
        errors     = 0;
    endfunction

    function void set_reg(logic [wpf_pkg::CFG_AW-1:0] addr, logic [15:0] val);
        case (addr)
            wpf_pkg::REG_ARRIVE_TOL: arrive_tol = 32'(val);
            wpf_pkg::REG_ANGLE_TOL:  angle_tol  = 32'(val[14:0]);
            wpf_pkg::REG_FWD_SPEED:  fwd_speed  = 32'(val);
            default:                 turn_rate  = 32'(val);
        endcase
    endfunction

    function bit [15:0] bam_atan2(longint y, longint x);
        bit [31:0] z;
        longint nx, ny;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h0080_0000;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (y < 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - atan_steps[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + atan_steps[i];
            end
            x = nx;
            y = ny;
        end
        z = (z + 32'd128) >> 8;
        return z[15:0];
    endfunction

    function void note_odometry(wpf_pkg::t_in_item it);
        longint qx, qy, qz, qw, px, py, dx, dy, tol, e, p, ang;
        bit [15:0] yaw, brg, eu;
        wpf_pkg::t_out_item cmd;
        qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
        px = it.pos_x;  py = it.pos_y;
        yaw = bam_atan2(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
        ang = 0;
        cmd = '0;
        if (!origin_set) begin
            origin_set = 1;
            org_x = px;
            org_y = py;
            org_yaw = yaw;
        end
        if (!all_done && wp_idx < NUM_WP) begin
            dx  = wp_xs[wp_idx] - (px - org_x);
            dy  = wp_ys[wp_idx] - (py - org_y);
            tol = arrive_tol;
            if (dx * dx + dy * dy < tol * tol) begin
                wp_idx++;
                if (wp_idx >= NUM_WP) all_done = 1;
            end else begin
                brg = bam_atan2(dy, dx);
                eu  = yaw - org_yaw - brg;
                e   = longint'(signed'(eu));
                if ((e < 0) ? (e < -longint'(angle_tol)) : (e > longint'(angle_tol))) begin
                    ang = (e < 0) ? longint'(turn_rate) : -longint'(turn_rate);
                end else begin
                    p   = longint'(turn_rate) * e * 51472;
                    cmd.linear_speed = fwd_speed[15:0];
                    ang = -((p + (64'sd1 <<< 28)) >>> 29);
                    if (ang > 524287) ang = 524287;
                    if (ang < -524288) ang = -524288;
                end
            end
        end else begin
            all_done = 1;
        end
        cmd.angular_rate = ang[19:0];
        cmd.target_index = wp_idx[2:0];
        cmd.finished     = all_done;
        cmd_q.push_back(cmd);
    endfunction

    function void check_command(wpf_pkg::t_out_item got);
        wpf_pkg::t_out_item want;
        if (cmd_q.size() == 0) begin
            $display("%0t: unexpected item, actual %h", $time, got);
            errors++;
            return;
        end
        want = cmd_q.pop_front();
        if (got.linear_speed !== want.linear_speed) begin
            $display("%0t: linear_speed expected %0d actual %0d", $time,
                     want.linear_speed, got.linear_speed);
            errors++;
        end
        if (got.angular_rate !== want.angular_rate) begin
            $display("%0t: angular_rate expected %0d actual %0d", $time,
                     want.angular_rate, got.angular_rate);
            errors++;
        end
        if (got.target_index !== want.target_index) begin
            $display("%0t: target_index expected %0d actual %0d", $time,
                     want.target_index, got.target_index);
            errors++;
        end
        if (got.finished !== want.finished) begin
            $display("%0t: finished expected %0d actual %0d", $time,
                     want.finished, got.finished);
            errors++;
        end
    endfunction
endclass

module waypoint_follow_controller_test;

    localparam int STALL_LIMIT = 3000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    wpf_pkg::t_in_item i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    wpf_pkg::t_out_item o_out;
    logic i_cfg_wr_en = 0;
    logic [wpf_pkg::CFG_AW-1:0] i_cfg_addr = '0;
    logic [wpf_pkg::CFG_DW-1:0] i_cfg_wdata = '0;

    steer_scoreboard sb = new();
    bit quiet = 0;
    int stall_cycles = 0;

    waypoint_follow_controller dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_command(o_out);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("waypoint_follow_controller_test NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_odometry(wpf_pkg::t_in_item it);
        if (!quiet && $urandom_range(99) < 20) begin
            i_in_valid <= 0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= it;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_odometry(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.cmd_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [wpf_pkg::CFG_AW-1:0] addr, logic [15:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        sb.set_reg(addr, val);
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        @(negedge i_clk);
    endtask

    task automatic write_all(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d);
        write_reg(wpf_pkg::REG_ARRIVE_TOL, a);
        write_reg(wpf_pkg::REG_ANGLE_TOL, b);
        write_reg(wpf_pkg::REG_FWD_SPEED, c);
        write_reg(wpf_pkg::REG_TURN_RATE, d);
    endtask

    function automatic wpf_pkg::t_in_item make_pose(longint x, longint y,
                                                     logic [15:0] qx,
                                                     logic [15:0] qy,
                                                     logic [15:0] qz,
                                                     logic [15:0] qw);
        wpf_pkg::t_in_item it;
        it.pos_x = x[23:0];
        it.pos_y = y[23:0];
        it.quat_x = qx;
        it.quat_y = qy;
        it.quat_z = qz;
        it.quat_w = qw;
        return it;
    endfunction

    function automatic wpf_pkg::t_in_item random_pose(bit aim);
        wpf_pkg::t_in_item it;
        longint x, y;
        int unsigned sel, k;
        sel = $urandom_range(99);
        k = (sb.wp_idx < 4) ? sb.wp_idx : 0;
        if (aim) begin
            x = sb.org_x + sb.wp_xs[k] + $signed($urandom_range(400)) - 200;
            y = sb.org_y + sb.wp_ys[k] + $signed($urandom_range(400)) - 200;
        end else if (sel < 65) begin
            x = sb.org_x + $signed($urandom_range(24576)) - 12288;
            y = sb.org_y + $signed($urandom_range(24576)) - 12288;
        end else begin
            x = $signed($urandom_range(24'hFFFFFF)) - 8388608;
            y = $signed($urandom_range(24'hFFFFFF)) - 8388608;
        end
        it = make_pose(x, y, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        if ($urandom_range(1)) begin
            it.quat_x = 16'($signed($urandom_range(32768)) - 16384);
            it.quat_y = 16'($signed($urandom_range(32768)) - 16384);
            it.quat_z = 16'($signed($urandom_range(32768)) - 16384);
            it.quat_w = 16'($signed($urandom_range(32768)) - 16384);
        end
        return it;
    endfunction

    initial begin
        logic [15:0] cfg_set[8][4];
        int wp_aim_cap;
        cfg_set = '{'{0, 0, 0, 0},
                    '{205, 32767, 65535, 65535},
                    '{1000, 1820, 410, 2048},
                    '{3, 16384, 1, 1},
                    '{0, 0, 0, 0},
                    '{0, 0, 0, 0},
                    '{300, 32767, 0, 65535},
                    '{65535, 0, 65535, 0}};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        write_reg(wpf_pkg::REG_ARRIVE_TOL, 16'd0);
        send_odometry(make_pose(0, 0, 0, 0, 0, 16'sd16384));
        send_odometry(make_pose(2048, 0, 0, 0, 0, 16'sd16384));
        send_odometry(make_pose(2048, 0, 0, 0, 16'sd16384, 0));
        send_odometry(make_pose(0, 0, 0, 0, 0, 0));
        send_odometry(make_pose(8388607, -8388608, 16'sd16384, 0, 0, 0));
        send_odometry(make_pose(-8388608, 8388607, 0, 16'sd16384, 0, 0));
        send_odometry(make_pose(-2048, 2048, -16'sd16384, -16'sd16384, -16'sd16384,
                                -16'sd16384));
        send_odometry(make_pose(100, -300, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_odometry(make_pose(-1, -1, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF));
        send_odometry(make_pose(0, 4096, 0, 0, 16'sd11585, 16'sd11585));
        send_odometry(make_pose(4096, -4096, 0, 0, -16'sd11585, 16'sd11585));
        drain();
        write_all(205, 1820, 410, 2048);
        send_odometry(make_pose(2048, 0, 0, 0, 0, 16'sd16384));
        send_odometry(make_pose(2048, 2000, 0, 0, 16'sd16384, 16'sd16384));
        send_odometry(make_pose(4096, 4096, 0, 0, 16'sd16384, -16'sd16384));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            for (int r = 0; r < 4; r++)
                if (ph == 2 || ph == 4 || ph == 5)
                    cfg_set[ph][r] = (r == 0) ? 16'($urandom_range(4096)) :
                                                16'($urandom);
            write_all(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2], cfg_set[ph][3]);
            quiet = (ph == 3);
            wp_aim_cap = (ph == 7) ? 4 : 3;
            for (int n = 0; n < 230; n++) begin
                if (ph == 2 && n == 100) drain();
                send_odometry(random_pose(sb.wp_idx < wp_aim_cap &&
                                          $urandom_range(99) < 5));
            end
            drain();
        end
        quiet = 0;

        while (sb.cmd_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("waypoint_follow_controller_test OK");
        end else begin
            $display("waypoint_follow_controller_test NOT OK");
        end
        $finish;
    end
endmodule
